>>> sv/ceim_pkg.sv
// ----------------------------------------------------------------------------
// ceim_pkg: shared types for the control error integral metrics block
// Microcode word layout, sequencer status, item kinds, widths and addresses.
// ----------------------------------------------------------------------------
package ceim_pkg;

    localparam int unsigned IN_DATA_W  = 136;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 464;
    localparam int unsigned OUT_USER_W = 1;
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [ADDR_W-1:0] ADDR_STEP_TIME = 3'd0;
    localparam logic [15:0]       STEP_TIME_RST  = 16'd1311;

    // Microprogram addresses.
    localparam int unsigned PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc S_FETCH = 5'd0;
    localparam t_pc S_SMP   = 5'd1;   // sixteen steps per channel
    localparam t_pc S_EPREP = 5'd17;
    localparam t_pc S_EMIT0 = 5'd18;
    localparam t_pc S_EMIT1 = 5'd19;
    localparam t_pc S_CLR   = 5'd20;
    localparam t_pc S_TACK  = 5'd21;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_TACK   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        A_AE, A_PROD, A_ATERM, A_STERM_LO, A_STERM_HI, A_DC, A_IAE_LO, A_IAE_HI
    } t_asel;

    typedef enum logic [2:0] {
        B_DT, B_AE, B_T, B_EN, B_IADC_LO, B_IADC_HI
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_NONE, ACC_LOAD, ACC_ADD
    } t_accop;

    typedef enum logic [3:0] {
        D_NONE, D_IAE, D_ISE, D_ITAE, D_ITSE, D_IADC, D_EPROD, D_FPROD, D_CLEAR, D_TACK
    } t_dst;

    typedef enum logic [1:0] {
        CH_KEEP, CH_CLR, CH_SET
    } t_chop;

    typedef enum logic [1:0] {
        J_NEXT, J_DISPATCH, J_GOTO, J_CH0
    } t_jmp;

    typedef struct packed {
        t_asel      a_sel;
        t_bsel      b_sel;
        t_accop     acc_op;
        logic [1:0] acc_word;
        t_dst       dst;
        t_chop      ch_op;
        t_jmp       jmp;
        logic       emit;
        t_pc        target;
    } t_ctl;

    typedef struct packed {
        logic                 in_valid;
        logic [IN_USER_W-1:0] in_kind;
        logic                 out_free;
        logic                 ch;
    } t_stat;

endpackage

>>> sv/ceim_seq.sv
// ----------------------------------------------------------------------------
// ceim_seq: microcode sequencer
// Step counter, control store and jump logic that drive the metrics datapath.
// ----------------------------------------------------------------------------
module ceim_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ceim_pkg::t_stat i_stat,
    output ceim_pkg::t_ctl  o_ctl
);
    import ceim_pkg::*;

    function automatic t_ctl uop(t_asel a, t_bsel b, t_accop op, logic [1:0] w,
                                 t_dst d, t_chop c, t_jmp j, logic e, t_pc tgt);
        t_ctl u;
        u.a_sel    = a;
        u.b_sel    = b;
        u.acc_op   = op;
        u.acc_word = w;
        u.dst      = d;
        u.ch_op    = c;
        u.jmp      = j;
        u.emit     = e;
        u.target   = tgt;
        return u;
    endfunction

    // The multiplier registers its product, so each step consumes the product
    // requested by the step before it.
    function automatic t_ctl rom(t_pc pc);
        t_ctl u;
        case (pc)
            S_FETCH:         u = uop(A_AE, B_DT, ACC_NONE, 2'd0, D_NONE, CH_CLR,
                                     J_DISPATCH, 1'b0, S_FETCH);
            S_SMP:           u = uop(A_AE, B_DT, ACC_NONE, 2'd0, D_NONE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd1:    u = uop(A_AE, B_AE, ACC_NONE, 2'd0, D_IAE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd2:    u = uop(A_PROD, B_DT, ACC_NONE, 2'd0, D_NONE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd3:    u = uop(A_ATERM, B_T, ACC_NONE, 2'd0, D_ISE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd4:    u = uop(A_STERM_LO, B_T, ACC_NONE, 2'd0, D_ITAE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd5:    u = uop(A_STERM_HI, B_T, ACC_LOAD, 2'd0, D_NONE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd6:    u = uop(A_DC, B_DT, ACC_ADD, 2'd1, D_NONE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd7:    u = uop(A_AE, B_DT, ACC_NONE, 2'd0, D_IADC, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd8:    u = uop(A_IAE_LO, B_EN, ACC_NONE, 2'd0, D_ITSE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd9:    u = uop(A_IAE_HI, B_EN, ACC_LOAD, 2'd0, D_NONE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd10:   u = uop(A_IAE_LO, B_IADC_LO, ACC_ADD, 2'd1, D_NONE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd11:   u = uop(A_IAE_LO, B_IADC_HI, ACC_LOAD, 2'd0, D_EPROD, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd12:   u = uop(A_IAE_HI, B_IADC_LO, ACC_ADD, 2'd1, D_NONE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd13:   u = uop(A_IAE_HI, B_IADC_HI, ACC_ADD, 2'd1, D_NONE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd14:   u = uop(A_AE, B_DT, ACC_ADD, 2'd2, D_NONE, CH_KEEP,
                                     J_NEXT, 1'b0, S_FETCH);
            S_SMP + 5'd15:   u = uop(A_AE, B_DT, ACC_NONE, 2'd0, D_FPROD, CH_SET,
                                     J_CH0, 1'b0, S_SMP);
            S_EPREP:         u = uop(A_AE, B_DT, ACC_NONE, 2'd0, D_NONE, CH_CLR,
                                     J_NEXT, 1'b0, S_FETCH);
            S_EMIT0:         u = uop(A_AE, B_DT, ACC_NONE, 2'd0, D_NONE, CH_SET,
                                     J_NEXT, 1'b1, S_FETCH);
            S_EMIT1:         u = uop(A_AE, B_DT, ACC_NONE, 2'd0, D_NONE, CH_KEEP,
                                     J_GOTO, 1'b1, S_FETCH);
            S_CLR:           u = uop(A_AE, B_DT, ACC_NONE, 2'd0, D_CLEAR, CH_KEEP,
                                     J_GOTO, 1'b0, S_EMIT0);
            S_TACK:          u = uop(A_AE, B_DT, ACC_NONE, 2'd0, D_TACK, CH_KEEP,
                                     J_GOTO, 1'b0, S_EMIT0);
            default:         u = uop(A_AE, B_DT, ACC_NONE, 2'd0, D_NONE, CH_KEEP,
                                     J_GOTO, 1'b0, S_FETCH);
        endcase
        return u;
    endfunction

    t_pc  r_pc;
    t_pc  n_pc;
    t_ctl w_ctl;

    assign w_ctl = rom(r_pc);
    assign o_ctl = w_ctl;

    always_comb begin
        n_pc = r_pc + 5'd1;
        case (w_ctl.jmp)
            J_NEXT: begin
                n_pc = r_pc + 5'd1;
            end
            J_DISPATCH: begin
                if (i_stat.in_valid) begin
                    case (t_kind'(i_stat.in_kind))
                        KIND_SAMPLE: n_pc = S_SMP;
                        KIND_CLEAR:  n_pc = S_CLR;
                        KIND_TACK:   n_pc = S_TACK;
                        default:     n_pc = S_EMIT0;
                    endcase
                end else begin
                    n_pc = r_pc;
                end
            end
            J_GOTO: begin
                n_pc = w_ctl.target;
            end
            J_CH0: begin
                if (!i_stat.ch) begin
                    n_pc = w_ctl.target;
                end
            end
            default: begin
                n_pc = S_FETCH;
            end
        endcase
        // A result step holds until the output register can take the result.
        if (w_ctl.emit && !i_stat.out_free) begin
            n_pc = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> sv/control_error_integral_metrics_top.sv
// ----------------------------------------------------------------------------
// control_error_integral_metrics_top: IAE/ISE/ITAE/ITSE/IADC metrics engine
// Tracks performance integrals for the speed and steering loops.
// ----------------------------------------------------------------------------
// Usage:
// An input transfer carries one item: a sample (kind 0), a metrics reset
// (kind 1) or a tack (kind 2). Every item, kind 3 included, answers with two
// result transfers: the speed channel first (tuser 0), then the steering
// channel (tuser 1, tlast high), both showing the state after the item.
// The APB port holds step_time (dt, Q0.16) at byte address 0; it is to be
// written only while the block is idle, which the block does not enforce.
// A sample runs 16 microcode steps per channel around a single registered
// 32x32 multiplier, then the two result steps. Reset and tack items run
// their update step and then the result steps; an unused kind 3 runs only
// the result steps.
// The block takes one item at a time and accepts the next input while the
// last result still waits in the output register.
// If the receiver stalls, the result steps hold the microprogram until the
// output register drains. After reset every accumulator, the tack count and
// the previous commands are zero and step_time is 1311.
// ----------------------------------------------------------------------------
module control_error_integral_metrics_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ceim_pkg::ADDR_W-1:0]         paddr,
    input  logic [ceim_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ceim_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Item input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // speed_error, steering_error, throttle_command, steering_command,
    // elapsed_ms, sail_energy, rudder_energy
    input  logic [ceim_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind
    input  logic [ceim_pkg::IN_USER_W-1:0]      s_axis_tuser,
    // Result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // abs_error_integral, squared_error_integral, time_abs_error_integral,
    // time_squared_error_integral, command_change_integral,
    // error_energy_product, error_effort_product, tack_count
    output logic [ceim_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // channel
    output logic [ceim_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    output logic                                m_axis_tlast
);
    import ceim_pkg::*;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    t_ctl w_ctl;
    t_stat w_stat;

    logic w_out_free;
    logic w_adv;
    logic w_in_fire;
    logic w_emit_fire;
    logic w_cfg_wr;

    logic [15:0]          r_dt;
    logic [IN_DATA_W-1:0] r_in_data;
    logic                 r_ch;
    logic [63:0]          r_prod;
    logic [127:0]         r_wide;
    logic [31:0]          r_aterm;
    logic [37:0]          r_sterm;

    logic [63:0] r_iae   [2];
    logic [63:0] r_ise   [2];
    logic [63:0] r_itae  [2];
    logic [63:0] r_itse  [2];
    logic [63:0] r_iadc  [2];
    logic [63:0] r_eprod [2];
    logic [63:0] r_fprod [2];
    logic [15:0] r_prev  [2];
    logic [15:0] r_tacks;

    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic                  r_ouser;
    logic                  r_olast;

    // Fields of the held item.
    logic [15:0] w_speed_err;
    logic [15:0] w_steer_err;
    logic [15:0] w_throttle;
    logic [15:0] w_steer_cmd;
    logic [23:0] w_elapsed;
    logic [23:0] w_sail_en;
    logic [23:0] w_rudder_en;

    assign w_speed_err = r_in_data[15:0];
    assign w_steer_err = r_in_data[31:16];
    assign w_throttle  = r_in_data[47:32];
    assign w_steer_cmd = r_in_data[63:48];
    assign w_elapsed   = r_in_data[87:64];
    assign w_sail_en   = r_in_data[111:88];
    assign w_rudder_en = r_in_data[135:112];

    // Channel-selected operands.
    logic [15:0]  w_err;
    logic [16:0]  w_err17;
    logic [16:0]  w_ae;
    logic [15:0]  w_cmd;
    logic [16:0]  w_diff;
    logic [16:0]  w_dc;
    logic [23:0]  w_energy;
    logic [63:0]  w_iae;
    logic [63:0]  w_iadc;
    logic [31:0]  w_mul_a;
    logic [31:0]  w_mul_b;
    logic [127:0] w_shp;
    logic [127:0] w_sum;
    logic [63:0]  w_eprod;
    logic [63:0]  w_fprod;

    assign w_err    = r_ch ? w_steer_err : w_speed_err;
    assign w_err17  = {w_err[15], w_err};
    assign w_ae     = w_err17[16] ? (17'd0 - w_err17) : w_err17;
    assign w_cmd    = r_ch ? w_steer_cmd : w_throttle;
    assign w_diff   = {w_cmd[15], w_cmd} - {r_prev[r_ch][15], r_prev[r_ch]};
    assign w_dc     = w_diff[16] ? (17'd0 - w_diff) : w_diff;
    assign w_energy = r_ch ? w_rudder_en : w_sail_en;
    assign w_iae    = r_iae[r_ch];
    assign w_iadc   = r_iadc[r_ch];

    always_comb begin
        case (w_ctl.a_sel)
            A_AE:       w_mul_a = {15'd0, w_ae};
            A_PROD:     w_mul_a = r_prod[31:0];
            A_ATERM:    w_mul_a = r_aterm;
            A_STERM_LO: w_mul_a = r_sterm[31:0];
            A_STERM_HI: w_mul_a = {26'd0, r_sterm[37:32]};
            A_DC:       w_mul_a = {15'd0, w_dc};
            A_IAE_LO:   w_mul_a = w_iae[31:0];
            A_IAE_HI:   w_mul_a = w_iae[63:32];
            default:    w_mul_a = '0;
        endcase
    end

    always_comb begin
        case (w_ctl.b_sel)
            B_DT:      w_mul_b = {16'd0, r_dt};
            B_AE:      w_mul_b = {15'd0, w_ae};
            B_T:       w_mul_b = {8'd0, w_elapsed};
            B_EN:      w_mul_b = {8'd0, w_energy};
            B_IADC_LO: w_mul_b = w_iadc[31:0];
            B_IADC_HI: w_mul_b = w_iadc[63:32];
            default:   w_mul_b = '0;
        endcase
    end

    // Partial products land at 32-bit word offsets in the wide accumulator.
    always_comb begin
        case (w_ctl.acc_word)
            2'd0:    w_shp = {64'd0, r_prod};
            2'd1:    w_shp = {32'd0, r_prod, 32'd0};
            2'd2:    w_shp = {r_prod, 64'd0};
            default: w_shp = '0;
        endcase
    end

    assign w_sum   = r_wide + w_shp;
    assign w_eprod = (|r_wide[127:72]) ? {64{1'b1}} : r_wide[71:8];
    assign w_fprod = (|r_wide[127:88]) ? {64{1'b1}} : r_wide[87:24];

    // Handshakes.
    assign s_axis_tready = (w_ctl.jmp == J_DISPATCH);
    assign w_in_fire     = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = ~r_ovalid | m_axis_tready;
    assign w_adv         = ~w_ctl.emit | w_out_free;
    assign w_emit_fire   = w_ctl.emit & w_out_free;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready & (paddr == ADDR_STEP_TIME);
    assign prdata   = (paddr == ADDR_STEP_TIME) ? {16'd0, r_dt} : '0;

    assign w_stat.in_valid = s_axis_tvalid;
    assign w_stat.in_kind  = s_axis_tuser;
    assign w_stat.out_free = w_out_free;
    assign w_stat.ch       = r_ch;

    ceim_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    // Control and metric state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt     <= STEP_TIME_RST;
            r_ch     <= 1'b0;
            r_ovalid <= 1'b0;
            r_tacks  <= '0;
            for (int c = 0; c < 2; c++) begin
                r_iae[c]   <= '0;
                r_ise[c]   <= '0;
                r_itae[c]  <= '0;
                r_itse[c]  <= '0;
                r_iadc[c]  <= '0;
                r_eprod[c] <= '0;
                r_fprod[c] <= '0;
                r_prev[c]  <= '0;
            end
        end else begin
            if (w_cfg_wr) begin
                r_dt <= pwdata[15:0];
            end

            if (w_adv) begin
                case (w_ctl.ch_op)
                    CH_CLR:  r_ch <= 1'b0;
                    CH_SET:  r_ch <= 1'b1;
                    default: r_ch <= r_ch;
                endcase
            end

            case (w_ctl.dst)
                D_IAE:   r_iae[r_ch]  <= sat_add(w_iae, r_prod);
                D_ISE:   r_ise[r_ch]  <= sat_add(r_ise[r_ch], {26'd0, r_prod[45:8]});
                D_ITAE:  r_itae[r_ch] <= sat_add(r_itae[r_ch], r_prod);
                D_ITSE:  r_itse[r_ch] <= sat_add(r_itse[r_ch], r_wide[63:0]);
                D_IADC:  r_iadc[r_ch] <= sat_add(w_iadc, r_prod);
                D_EPROD: r_eprod[r_ch] <= w_eprod;
                D_FPROD: begin
                    r_fprod[r_ch] <= w_fprod;
                    r_prev[r_ch]  <= w_cmd;
                end
                D_CLEAR: begin
                    // The command change integral and both products survive.
                    for (int c = 0; c < 2; c++) begin
                        r_iae[c]  <= '0;
                        r_ise[c]  <= '0;
                        r_itae[c] <= '0;
                        r_itse[c] <= '0;
                    end
                    r_tacks <= '0;
                end
                D_TACK: begin
                    if (r_tacks != {16{1'b1}}) begin
                        r_tacks <= r_tacks + 16'd1;
                    end
                end
                default: begin
                end
            endcase

            if (w_emit_fire) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_data <= s_axis_tdata;
        end

        r_prod <= {32'd0, w_mul_a} * {32'd0, w_mul_b};

        if (w_ctl.dst == D_IAE) begin
            r_aterm <= r_prod[31:0];
        end
        if (w_ctl.dst == D_ISE) begin
            r_sterm <= r_prod[45:8];
        end

        case (w_ctl.acc_op)
            ACC_LOAD: r_wide <= w_shp;
            ACC_ADD:  r_wide <= w_sum;
            default:  r_wide <= r_wide;
        endcase

        if (w_emit_fire) begin
            r_odata <= {r_tacks, r_fprod[r_ch], r_eprod[r_ch], r_iadc[r_ch],
                        r_itse[r_ch], r_itae[r_ch], r_ise[r_ch], r_iae[r_ch]};
            r_ouser <= r_ch;
            r_olast <= r_ch;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule

>>> sim/control_error_integral_metrics_top_test.sv
// ----------------------------------------------------------------------------
// control_error_integral_metrics_top_test: self-checking bench for the metrics engine
// Feeds sample, metrics reset, tack and unused items through the input stream,
// rewrites step_time over APB between phases, and checks both result transfers
// of every item against a predictor of the two channels' integrals.
// ----------------------------------------------------------------------------
module control_error_integral_metrics_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ceim_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 425;

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] speed_err;
        logic signed [15:0] steer_err;
        logic signed [15:0] throttle_cmd;
        logic signed [15:0] steer_cmd;
        logic [23:0]        elapsed_ms;
        logic [23:0]        sail_energy;
        logic [23:0]        rudder_energy;
    } t_metrics_item;

    typedef struct {
        logic        channel;
        logic [63:0] iae;
        logic [63:0] ise;
        logic [63:0] itae;
        logic [63:0] itse;
        logic [63:0] iadc;
        logic [63:0] energy_prod;
        logic [63:0] effort_prod;
        logic [15:0] tacks;
        logic        last;
    } t_metrics_result;

    typedef enum {ROW_ITEM, ROW_STEP} t_plan_op;

    typedef struct {
        t_plan_op      op;
        logic [15:0]   step;
        t_metrics_item item;
        bit            known;
        logic [63:0]   speed_iae;
        logic [63:0]   steer_iae;
        logic [15:0]   tacks;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_W-1:0]     paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    control_error_integral_metrics_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predicted state of both channels.
    logic [63:0]        iae_sum[2];
    logic [63:0]        ise_sum[2];
    logic [63:0]        itae_sum[2];
    logic [63:0]        itse_sum[2];
    logic [63:0]        iadc_sum[2];
    logic [63:0]        energy_prod[2];
    logic [63:0]        effort_prod[2];
    logic signed [15:0] prev_cmd[2];
    logic [15:0]        tack_total;
    logic [15:0]        dt_q16;

    t_metrics_result expected_metrics[$];
    t_plan_row       plan[$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    bit          hold_req       = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned cycles         = 0;
    int unsigned mismatches     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] scaled_product(input logic [63:0] a,
                                                   input logic [63:0] b, input int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p[127:64] != 64'd0) ? '1 : p[63:0];
    endfunction

    task automatic advance_channel(input int ch, input logic signed [15:0] err,
                                   input logic signed [15:0] cmd, input logic [23:0] t,
                                   input logic [23:0] energy);
        logic [63:0] ae;
        logic [63:0] a_term;
        logic [63:0] s_term;
        logic [63:0] dc;
        int          d;
        ae     = (err < 0) ? 64'(-int'(err)) : 64'(int'(err));
        a_term = ae * 64'(dt_q16);
        s_term = (ae * ae * 64'(dt_q16)) >> 8;
        d      = int'(cmd) - int'(prev_cmd[ch]);
        dc     = (d < 0) ? 64'(-d) : 64'(d);
        iae_sum[ch]     = sat_sum(iae_sum[ch], a_term);
        ise_sum[ch]     = sat_sum(ise_sum[ch], s_term);
        itae_sum[ch]    = sat_sum(itae_sum[ch], a_term * 64'(t));
        itse_sum[ch]    = sat_sum(itse_sum[ch], s_term * 64'(t));
        iadc_sum[ch]    = sat_sum(iadc_sum[ch], dc * 64'(dt_q16));
        energy_prod[ch] = scaled_product(iae_sum[ch], 64'(energy), 8);
        effort_prod[ch] = scaled_product(iae_sum[ch], iadc_sum[ch], 24);
        prev_cmd[ch]    = cmd;
    endtask

    // Applies one accepted item and queues the pair of results it produces.
    task automatic advance_metrics(input t_metrics_item it);
        t_metrics_result r;
        if (it.kind == KIND_SAMPLE) begin
            advance_channel(0, it.speed_err, it.throttle_cmd, it.elapsed_ms, it.sail_energy);
            advance_channel(1, it.steer_err, it.steer_cmd, it.elapsed_ms, it.rudder_energy);
        end else if (it.kind == KIND_CLEAR) begin
            for (int c = 0; c < 2; c++) begin
                iae_sum[c]  = '0;
                ise_sum[c]  = '0;
                itae_sum[c] = '0;
                itse_sum[c] = '0;
            end
            tack_total = '0;
        end else if (it.kind == KIND_TACK) begin
            if (tack_total != 16'hFFFF) tack_total++;
        end
        for (int c = 0; c < 2; c++) begin
            r.channel     = c[0];
            r.iae         = iae_sum[c];
            r.ise         = ise_sum[c];
            r.itae        = itae_sum[c];
            r.itse        = itse_sum[c];
            r.iadc        = iadc_sum[c];
            r.energy_prod = energy_prod[c];
            r.effort_prod = effort_prod[c];
            r.tacks       = tack_total;
            r.last        = (c == 1);
            expected_metrics.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_metrics_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_metrics.size() == 0) begin
                mismatches++;
                $error("result transfer with no result pending");
            end else begin
                want = expected_metrics.pop_front();
                compare_field("channel", 64'(want.channel), 64'(m_axis_tuser[0]));
                compare_field("abs_error_integral", want.iae, m_axis_tdata[0 +: 64]);
                compare_field("squared_error_integral", want.ise, m_axis_tdata[64 +: 64]);
                compare_field("time_abs_error_integral", want.itae, m_axis_tdata[128 +: 64]);
                compare_field("time_squared_error_integral", want.itse,
                              m_axis_tdata[192 +: 64]);
                compare_field("command_change_integral", want.iadc, m_axis_tdata[256 +: 64]);
                compare_field("error_energy_product", want.energy_prod,
                              m_axis_tdata[320 +: 64]);
                compare_field("error_effort_product", want.effort_prod,
                              m_axis_tdata[384 +: 64]);
                compare_field("tack_count", 64'(want.tacks), 64'(m_axis_tdata[448 +: 16]));
                compare_field("last_of_run", 64'(want.last), 64'(m_axis_tlast));
            end
        end
    end

    // Receiver side: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Stimulus tasks are entered and left just after a falling edge.
    task automatic offer_item(input t_metrics_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {it.rudder_energy, it.sail_energy, it.elapsed_ms, it.steer_cmd,
                          it.throttle_cmd, it.steer_err, it.speed_err};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_metrics(it);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_metrics.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_step_time(input logic [15:0] value);
        logic [APB_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_STEP_TIME;
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        dt_q16 = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[15:0] !== value) begin
            mismatches++;
            $error("step_time readback: expected %0h, got %0h", value, rd[15:0]);
        end
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick24();
        case ($urandom_range(0, 9))
            0: return 24'hFFFFFF;
            1: return 24'h000000;
            2, 3: return 24'($urandom_range(0, 1000));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_metrics_item random_item();
        t_metrics_item it;
        int unsigned   pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)      it.kind = KIND_SAMPLE;
        else if (pick < 84) it.kind = KIND_CLEAR;
        else if (pick < 94) it.kind = KIND_TACK;
        else                it.kind = KIND_UNUSED;
        it.speed_err     = pick16();
        it.steer_err     = pick16();
        it.throttle_cmd  = pick16();
        it.steer_cmd     = pick16();
        it.elapsed_ms    = pick24();
        it.sail_energy   = pick24();
        it.rudder_energy = pick24();
        return it;
    endfunction

    function automatic void add_row(input logic [1:0] kind, input logic [15:0] se,
                                    input logic [15:0] te, input logic [15:0] tc,
                                    input logic [15:0] sc, input logic [23:0] ms,
                                    input logic [23:0] sail, input logic [23:0] rudder,
                                    input bit known, input logic [63:0] speed_iae,
                                    input logic [63:0] steer_iae, input logic [15:0] tacks);
        t_plan_row row;
        row.op        = ROW_ITEM;
        row.step      = '0;
        row.item      = '{kind, se, te, tc, sc, ms, sail, rudder};
        row.known     = known;
        row.speed_iae = speed_iae;
        row.steer_iae = steer_iae;
        row.tacks     = tacks;
        plan.push_back(row);
    endfunction

    function automatic void add_step(input logic [15:0] step);
        t_plan_row row;
        row.op        = ROW_STEP;
        row.step      = step;
        row.item      = '{KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 0};
        row.known     = 1'b0;
        row.speed_iae = '0;
        row.steer_iae = '0;
        row.tacks     = '0;
        plan.push_back(row);
    endfunction

    initial begin : stimulus
        t_metrics_item it;
        int            last_idx;
        for (int c = 0; c < 2; c++) begin
            iae_sum[c]     = '0;
            ise_sum[c]     = '0;
            itae_sum[c]    = '0;
            itse_sum[c]    = '0;
            iadc_sum[c]    = '0;
            energy_prod[c] = '0;
            effort_prod[c] = '0;
            prev_cmd[c]    = '0;
        end
        tack_total = '0;
        dt_q16     = STEP_TIME_RST;

        // Directed table. Rows with known set carry the IAE of both channels and
        // the tack count, read straight off the arithmetic at the step_time in force.
        add_row(KIND_UNUSED, 16'h1234, 16'h8000, 16'h7FFF, 16'h0001, 24'hFFFFFF,
                24'hFFFFFF, 24'hFFFFFF, 1, 0, 0, 0);
        add_row(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_TACK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1);
        add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1);
        // First real sample: command change measured from zero.
        add_row(KIND_SAMPLE, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 0, 0, 0,
                1, 64'd42958848, 64'd42957537, 1);
        add_row(KIND_SAMPLE, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 24'hFFFFFF,
                24'hFFFFFF, 24'hFFFFFF, 1, 64'd85916385, 64'd85916385, 1);
        add_row(KIND_TACK, 0, 0, 0, 0, 0, 0, 0, 1, 64'd85916385, 64'd85916385, 2);
        // Metrics reset keeps IADC and the products.
        add_row(KIND_CLEAR, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_UNUSED, 16'h8000, 16'h8000, 16'h0100, 16'hFF00, 24'h000001,
                24'h800000, 24'h000001, 1, 0, 0, 0);
        add_step(16'd0);
        add_row(KIND_SAMPLE, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 24'hFFFFFF,
                24'hFFFFFF, 24'hFFFFFF, 1, 0, 0, 0);
        add_step(16'hFFFF);
        // Full-scale samples with a large time weight drive ITSE into saturation.
        for (int k = 0; k < 5; k++)
            add_row(KIND_SAMPLE, k[0] ? 16'h7FFF : 16'h8000, 16'h8000,
                    k[0] ? 16'h8000 : 16'h7FFF, k[0] ? 16'h7FFF : 16'h8000,
                    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 24'h000001,
                24'h000001, 24'h000000, 0, 0, 0, 0);
        add_row(KIND_TACK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_step(16'd1);
        add_row(KIND_SAMPLE, 16'h0001, 16'hFFFF, 16'h0000, 16'h0001, 24'h000010,
                24'h000100, 24'h000100, 0, 0, 0, 0);
        add_row(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].op == ROW_STEP) begin
                drain_results();
                write_step_time(plan[k].step);
            end else begin
                offer_item(plan[k].item);
                if (plan[k].known) begin
                    last_idx = expected_metrics.size() - 1;
                    expected_metrics[last_idx - 1].iae   = plan[k].speed_iae;
                    expected_metrics[last_idx].iae       = plan[k].steer_iae;
                    expected_metrics[last_idx - 1].tacks = plan[k].tacks;
                    expected_metrics[last_idx].tacks     = plan[k].tacks;
                end
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    src_idle_pct = 0;  sink_stall_pct = 0;
                    write_step_time(16'($urandom_range(1, 65535)));
                end
                1: begin
                    src_idle_pct = 63; sink_stall_pct = 0;
                    write_step_time(16'hFFFF);
                end
                2: begin
                    src_idle_pct = 0;  sink_stall_pct = 63;
                    write_step_time(16'd1);
                end
                default: begin
                    src_idle_pct = 14; sink_stall_pct = 14;
                    write_step_time(16'($urandom_range(1, 65535)));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The receiver holds off while items keep coming, so the input stalls.
                if (ph == 0 && n == 100) hold_req = 1'b1;
                if (ph == 1 && n == 200) drain_results();
                offer_item(random_item());
            end
        end

        // A closing sample and metrics reset at the reset step time.
        drain_results();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_step_time(STEP_TIME_RST);
        it      = random_item();
        it.kind = KIND_SAMPLE;
        offer_item(it);
        it.kind = KIND_CLEAR;
        offer_item(it);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_metrics.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
